[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define HRCP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also watches reset cycles.
`define HRCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/hrcp_pkg.sv]
// Package: types and constants of the hex record character parser.
`default_nettype none

package hrcp_pkg;

    // Character position counter
    localparam int POS_W = 10;
    localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

    // Positions inside the record header
    localparam logic [POS_W-1:0] POS_COUNT_HI = 10'd1;
    localparam logic [POS_W-1:0] POS_COUNT_LO = 10'd2;
    localparam logic [POS_W-1:0] POS_ADDR_3   = 10'd3;
    localparam logic [POS_W-1:0] POS_ADDR_2   = 10'd4;
    localparam logic [POS_W-1:0] POS_ADDR_1   = 10'd5;
    localparam logic [POS_W-1:0] POS_ADDR_0   = 10'd6;
    localparam logic [POS_W-1:0] POS_HDR_END  = 10'd8;
    localparam logic [POS_W-1:0] LINE_BASE    = 10'd9;

    // Phase of a data character inside its four-character word
    localparam logic [1:0] PH_LO_HI = 2'd1;
    localparam logic [1:0] PH_LO_LO = 2'd2;
    localparam logic [1:0] PH_HI_HI = 2'd3;
    localparam logic [1:0] PH_HI_LO = 2'd0;

    localparam logic [7:0] COLON_CHAR = 8'h3A;

    localparam int SLOT_OUT_W = 6;
    localparam int DEF_RING_DEPTH = 64;

    typedef enum logic [1:0] {
        KIND_COUNT = 2'd0,
        KIND_ADDR  = 2'd1,
        KIND_DATA  = 2'd2
    } t_word_kind;

    typedef struct packed {
        logic [15:0]           value;
        logic [SLOT_OUT_W-1:0] slot;
        t_word_kind            kind;
        logic [15:0]           total;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/hrcp_nibble.sv]
// Character decode: hex digit value and record start mark.
`default_nettype none

module hrcp_nibble (
    input  wire logic [7:0] i_char,
    output logic [3:0]      o_nibble,
    output logic            o_colon
);
    import hrcp_pkg::*;

    // Upper-case hex digits only; anything else reads as zero
    always_comb begin
        o_nibble = 4'd0;
        if (i_char >= 8'h30 && i_char <= 8'h39) begin
            o_nibble = i_char[3:0];
        end else if (i_char >= 8'h41 && i_char <= 8'h46) begin
            o_nibble = i_char[3:0] + 4'd9;
        end
    end

    assign o_colon = (i_char == COLON_CHAR);

endmodule

`default_nettype wire

[rtl/core/hrcp_engine.sv]
// Parser state and single-pass result computation for one character.
`default_nettype none

module hrcp_engine #(
    parameter int RING_DEPTH = hrcp_pkg::DEF_RING_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire logic [3:0]      i_nibble,
    input  wire logic            i_colon,
    output logic                 o_emit,
    output hrcp_pkg::t_result    o_result
);
    import hrcp_pkg::*;

    localparam int SLOT_W = $clog2(RING_DEPTH);

    logic [POS_W-1:0]  r_pos,      n_pos;
    logic [POS_W-1:0]  r_line_len, n_line_len;
    logic [15:0]       r_low,      n_low;
    logic [15:0]       r_high,     n_high;
    logic [SLOT_W-1:0] r_slot,     n_slot;
    logic [15:0]       r_count,    n_count;

    logic [POS_W-1:0]       pos;
    logic [15:0]            nib16;
    logic [15:0]            sum_low;
    logic [15:0]            sum_high;
    logic                   emit;
    t_word_kind             kind;
    logic [15:0]            value;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

    assign pos   = i_colon ? '0 : r_pos;
    assign nib16 = {12'd0, i_nibble};
    assign sum_low  = r_low + nib16;
    assign sum_high = r_high + nib16;
    assign slot_ext = {{SLOT_OUT_W{1'b0}}, r_slot};

    // Header fields, then data words while inside the line
    always_comb begin
        n_line_len = r_line_len;
        n_low      = r_low;
        n_high     = r_high;
        n_count    = r_count;
        emit       = 1'b0;
        kind       = KIND_COUNT;
        value      = sum_low;

        unique case (pos)
            POS_COUNT_HI, POS_ADDR_3: begin
                n_low = {8'd0, i_nibble, 4'd0};
            end
            POS_COUNT_LO: begin
                n_low      = sum_low;
                n_line_len = LINE_BASE + {1'b0, sum_low[7:0], 1'b0};
                emit       = 1'b1;
                kind       = KIND_COUNT;
                value      = sum_low;
            end
            POS_ADDR_2: begin
                n_low = {sum_low[7:0], 8'd0};
            end
            POS_ADDR_1: begin
                n_low = r_low + {8'd0, i_nibble, 4'd0};
            end
            POS_ADDR_0: begin
                n_low = sum_low;
                emit  = 1'b1;
                kind  = KIND_ADDR;
                value = sum_low;
            end
            default: begin
            end
        endcase

        if (pos > POS_HDR_END && pos < r_line_len) begin
            unique case (pos[1:0])
                PH_LO_HI: n_low  = {8'd0, i_nibble, 4'd0};
                PH_LO_LO: n_low  = sum_low;
                PH_HI_HI: n_high = {8'd0, i_nibble, 4'd0};
                PH_HI_LO: begin
                    // byte-swapped word: second byte lands in the high half
                    n_high  = {sum_high[7:0], 8'd0};
                    n_low   = r_low + {sum_high[7:0], 8'd0};
                    n_count = r_count + 16'd1;
                    emit    = 1'b1;
                    kind    = KIND_DATA;
                    value   = r_low + {sum_high[7:0], 8'd0};
                end
                default: begin
                end
            endcase
        end
    end

    // Position and ring slot advance
    always_comb begin
        n_pos = (pos < POS_MAX) ? pos + 10'd1 : pos;
        if (emit) begin
            n_slot = (r_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : r_slot + SLOT_W'(1);
        end else begin
            n_slot = r_slot;
        end
    end

    always_comb begin
        o_emit         = emit;
        o_result.value = value;
        o_result.slot  = slot_ext[SLOT_OUT_W-1:0];
        o_result.kind  = kind;
        o_result.total = n_count;
    end

    // State update on each processed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_line_len <= '0;
            r_low      <= '0;
            r_high     <= '0;
            r_slot     <= '0;
            r_count    <= '0;
        end else if (i_fire) begin
            r_pos      <= n_pos;
            r_line_len <= n_line_len;
            r_low      <= n_low;
            r_high     <= n_high;
            r_slot     <= n_slot;
            r_count    <= n_count;
        end
    end

endmodule

`default_nettype wire

[rtl/core/hrcp_out_reg.sv]
// Result register holding one finished transaction for the output side.
`default_nettype none

module hrcp_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  hrcp_pkg::t_result       i_result,
    output logic                    o_can_load,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output hrcp_pkg::t_result       o_result
);
    import hrcp_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_data;

    // Valid flag: set on load, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

endmodule

`default_nettype wire

[rtl/core/hex_record_char_parser_top.sv]
// Path: an accepted character is held in the input register, and its result is
//   offered from the result register.
// Throughput: one character per cycle; a character waits in the input register
//   while the result register holds a result the receiver has not taken.
// Reset (synchronous, active low) clears position, line length,
//   accumulators, ring slot, word count and both valid flags.
`default_nettype none

module hex_record_char_parser_top #(
    parameter int RING_DEPTH = hrcp_pkg::DEF_RING_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_char,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_word_value,
    output logic [5:0]       o_slot_index,
    output logic [1:0]       o_word_kind,
    output logic [15:0]      o_data_words_total
);
    import hrcp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic [3:0] nibble;
    logic       colon;
    logic       fire;
    logic       can_load;
    logic       emit;
    t_result    result;
    t_result    out_result;

    assign fire    = r_in_valid && can_load;
    assign o_ready = !r_in_valid || fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_char <= i_rx_char;
        end
    end

    hrcp_nibble u_nibble (
        .i_char   (r_in_char),
        .o_nibble (nibble),
        .o_colon  (colon)
    );

    hrcp_engine #(
        .RING_DEPTH (RING_DEPTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_nibble (nibble),
        .i_colon  (colon),
        .o_emit   (emit),
        .o_result (result)
    );

    hrcp_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && emit),
        .i_result   (result),
        .o_can_load (can_load),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_result   (out_result)
    );

    assign o_word_value       = out_result.value;
    assign o_slot_index       = out_result.slot;
    assign o_word_kind        = out_result.kind;
    assign o_data_words_total = out_result.total;

endmodule

`default_nettype wire

[rtl/core/hrcp_checker.sv]
// Port-level checker for the parser top level, with its bind.
`default_nettype none

`include "assert_macros.svh"

module hrcp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [7:0]  i_rx_char,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [15:0] o_word_value,
    input wire logic [5:0]  o_slot_index,
    input wire logic [1:0]  o_word_kind,
    input wire logic [15:0] o_data_words_total
);
    import hrcp_pkg::*;

    logic [39:0] out_bus;
    logic        out_stall;
    logic        in_stall;
    logic        count_word;

    assign out_bus    = {o_word_value, o_slot_index, o_word_kind, o_data_words_total};
    assign out_stall  = o_valid && !i_ready;
    assign in_stall   = i_valid && !o_ready;
    assign count_word = o_valid && (o_word_kind == KIND_COUNT);

    // A stalled result transaction stays offered and unchanged
    `HRCP_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> o_valid && $stable(out_bus), "result moved")

    // A stalled input transaction stays offered and unchanged
    `HRCP_ASSERT(a_in_hold, i_clk, i_rst_n, in_stall |=> i_valid && $stable(i_rx_char), "input moved")

    // Reset empties the result register
    `HRCP_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

    // Only the three word kinds are produced
    `HRCP_ASSERT(a_kind, i_clk, i_rst_n, o_valid |-> o_word_kind <= KIND_DATA, "bad word kind")

    // A byte count is assembled from two hex digits only
    `HRCP_ASSERT(a_count_byte, i_clk, i_rst_n, count_word |-> o_word_value[15:8] == 8'd0, "wide count")

endmodule

bind hex_record_char_parser_top hrcp_checker u_hrcp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .i_rx_char          (i_rx_char),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_word_value       (o_word_value),
    .o_slot_index       (o_slot_index),
    .o_word_kind        (o_word_kind),
    .o_data_words_total (o_data_words_total)
);

`default_nettype wire
